### rtl/core/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants of the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

   localparam int ACTION_W  = 2;
   localparam int PROG_W    = 3;
   localparam int BADDR_W   = 6;
   localparam int BYTE_W    = 8;
   localparam int TICKS_W   = 16;

   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd3;

   localparam logic [BYTE_W-1:0] END_MARK       = 8'hFF;
   localparam logic [BYTE_W-1:0] WRAP_MAX       = 8'hFF;
   localparam logic [BYTE_W-1:0] LED_MASK_RESET = 8'h03;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [PROG_W-1:0]   program_req;
      logic [BADDR_W-1:0]  byte_address;
      logic [BYTE_W-1:0]   write_data;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] port_value;
      logic              running;
      logic [BYTE_W-1:0] repeats;
   } rsp_word_type;

   typedef struct packed {
      logic take;
      logic done;
   } eng_stat_type;

endpackage

### rtl/core/lps_if.sv
// ----------------------------------------------------------------------------
// lps_req_if / lps_rsp_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface lps_req_if;
   import lps_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [PROG_W-1:0]   program_req;
   logic [BADDR_W-1:0]  byte_address;
   logic [BYTE_W-1:0]   write_data;

   modport source (output valid, action, program_req, byte_address, write_data,
                   input ready);
   modport sink   (input valid, action, program_req, byte_address, write_data,
                   output ready);
endinterface

interface lps_rsp_if;
   import lps_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] port_value;
   logic              running;
   logic [BYTE_W-1:0] repeats;

   modport source (output valid, port_value, running, repeats, input ready);
   modport sink   (input valid, port_value, running, repeats, output ready);
endinterface

### rtl/core/lps_store.sv
// ----------------------------------------------------------------------------
// lps_store
// Program memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lps_store #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [lps_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [lps_pkg::BYTE_W-1:0] rd_data
);
   import lps_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lps_engine.sv
// ----------------------------------------------------------------------------
// lps_engine
// Player state and fetch sequencer; reads pattern and duration from the store.
// ----------------------------------------------------------------------------
module lps_engine #(
   parameter int PROGRAM_SLOTS = 8,
   parameter int PROGRAM_BYTES = 64,
   parameter int AW            = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [lps_pkg::BYTE_W-1:0] csr_wdata,
   input  logic                      item_valid,
   input  lps_pkg::req_word_type     item_word,
   input  logic                      out_free,
   output lps_pkg::eng_stat_type     stat,
   output lps_pkg::rsp_word_type     result,
   output logic                      wr_en,
   output logic [AW-1:0]             wr_addr,
   output logic [lps_pkg::BYTE_W-1:0] wr_data,
   output logic                      rd_en,
   output logic [AW-1:0]             rd_addr,
   input  logic [lps_pkg::BYTE_W-1:0] rd_data
);
   import lps_pkg::*;

   localparam int PW  = $clog2(PROGRAM_BYTES);
   localparam int PGW = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PAT   = 2'd1;
   localparam logic [1:0] ST_RETRY = 2'd2;
   localparam logic [1:0] ST_DUR   = 2'd3;

   function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (32'(p) + 32'd1 == PROGRAM_BYTES) begin
         r = '0;
      end else begin
         r = p + PW'(1);
      end
      return r;
   endfunction

   logic [1:0]         state_ff,   state_in;
   logic [PGW-1:0]     active_ff,  active_in;
   logic [PW-1:0]      pos_ff,     pos_in;
   logic [TICKS_W-1:0] ticks_ff,   ticks_in;
   logic               playing_ff, playing_in;
   logic [BYTE_W-1:0]  wraps_ff,   wraps_in;
   logic [BYTE_W-1:0]  port_ff,    port_in;
   logic [BYTE_W-1:0]  mask_ff;

   logic [PW-1:0]      rd_pos;
   logic [AW-1:0]      base_addr;
   logic               prog_ok;
   logic               addr_ok;
   logic [BYTE_W-1:0]  merged;

   assign base_addr = AW'(active_ff) * AW'(PROGRAM_BYTES);
   assign rd_addr   = base_addr + AW'(rd_pos);
   assign prog_ok   = 32'(item_word.program_req) < PROGRAM_SLOTS;
   assign addr_ok   = 32'(item_word.byte_address) < PROGRAM_BYTES;
   assign merged    = (port_ff & ~mask_ff) | (rd_data & mask_ff);
   assign wr_addr   = AW'(item_word.program_req) * AW'(PROGRAM_BYTES)
                    + AW'(item_word.byte_address);
   assign wr_data   = item_word.write_data;

   always_comb begin
      state_in   = state_ff;
      active_in  = active_ff;
      pos_in     = pos_ff;
      ticks_in   = ticks_ff;
      playing_in = playing_ff;
      wraps_in   = wraps_ff;
      port_in    = port_ff;
      rd_en      = 1'b0;
      rd_pos     = pos_ff;
      wr_en      = 1'b0;
      stat.take  = 1'b0;
      stat.done  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid && out_free) begin
               stat.take = 1'b1;
               stat.done = 1'b1;
               case (item_word.action)
                  ACT_TICK: begin
                     if (playing_ff) begin
                        if (ticks_ff != '0) begin
                           ticks_in = ticks_ff - TICKS_W'(1);
                        end else begin
                           stat.done = 1'b0;
                           rd_en     = 1'b1;
                           pos_in    = next_pos(pos_ff);
                           state_in  = ST_PAT;
                        end
                     end
                  end
                  ACT_START: begin
                     if (prog_ok && !(playing_ff &&
                         32'(item_word.program_req) == 32'(active_ff))) begin
                        active_in  = PGW'(item_word.program_req);
                        pos_in     = '0;
                        ticks_in   = '0;
                        wraps_in   = '0;
                        playing_in = 1'b1;
                     end
                  end
                  ACT_STOP: begin
                     playing_in = 1'b0;
                     port_in    = port_ff | mask_ff;
                  end
                  default: begin
                     wr_en = prog_ok && addr_ok;
                  end
               endcase
            end
         end
         ST_PAT: begin
            rd_en = 1'b1;
            if (rd_data == END_MARK) begin
               if (wraps_ff != WRAP_MAX) begin
                  wraps_in = wraps_ff + BYTE_W'(1);
               end
               rd_pos   = '0;
               pos_in   = next_pos('0);
               state_in = ST_RETRY;
            end else begin
               port_in  = merged;
               pos_in   = next_pos(pos_ff);
               state_in = ST_DUR;
            end
         end
         ST_RETRY: begin
            rd_en    = 1'b1;
            port_in  = merged;
            pos_in   = next_pos(pos_ff);
            state_in = ST_DUR;
         end
         ST_DUR: begin
            ticks_in  = {8'h00, rd_data} - TICKS_W'(1);
            stat.done = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result.port_value = port_in;
   assign result.running    = playing_in;
   assign result.repeats    = wraps_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         active_ff  <= '0;
         pos_ff     <= '0;
         ticks_ff   <= '0;
         playing_ff <= 1'b0;
         wraps_ff   <= '0;
         port_ff    <= '0;
         mask_ff    <= LED_MASK_RESET;
      end else begin
         state_ff   <= state_in;
         active_ff  <= active_in;
         pos_ff     <= pos_in;
         ticks_ff   <= ticks_in;
         playing_ff <= playing_in;
         wraps_ff   <= wraps_in;
         port_ff    <= port_in;
         if (csr_we) begin
            mask_ff <= csr_wdata;
         end
      end
   end

`ifndef SYNTHESIS
   a_take_only_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !stat.take)
      else $error("word taken during fetch");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_IDLE && item_word.action == ACT_WRITE)
      else $error("store write outside a write word");

   a_fetch_while_playing: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> playing_ff)
      else $error("fetch while stopped");

   a_pattern_to_duration: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAT && rd_data != END_MARK |=> state_ff == ST_DUR)
      else $error("pattern not followed by duration read");
`endif

endmodule

### rtl/core/led_pattern_sequencer_unit.sv
// ----------------------------------------------------------------------------
// led_pattern_sequencer_unit
// Tick-driven LED pattern player with a program memory loaded by words.
//
//   channel   direction  payload                                      ready
//   req_ch    in         action, program_req, byte_address, write_data  yes
//   rsp_ch    out        port_value, running, repeats                  yes
//   csr_*     in         led_mask (write only)                         no
//
// Start, stop, write and counting ticks finish in the engine's idle state.
// A reload tick steps ST_PAT, ST_RETRY (at the end marker), ST_DUR: the single
// read port of the program memory serves the pattern, rewind and duration reads.
// A one-word input buffer feeds the engine; a full, stalled output register holds it.
// Reset clears the player state; memory content is undefined until written.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_unit #(
   parameter int PROGRAM_SLOTS = 8,
   parameter int PROGRAM_BYTES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   lps_req_if.sink                   req_ch,
   lps_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [lps_pkg::BYTE_W-1:0] csr_wdata
);
   import lps_pkg::*;

   localparam int DEPTH = PROGRAM_SLOTS * PROGRAM_BYTES;
   localparam int AW    = $clog2(DEPTH);

   req_word_type      req_word;
   logic              buf_valid_ff, buf_valid_in;
   req_word_type      buf_word_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_word_type      out_word_ff;
   rsp_word_type      result;
   eng_stat_type      stat;
   logic              out_free;
   logic              req_take;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;

   assign req_word.action       = req_ch.action;
   assign req_word.program_req  = req_ch.program_req;
   assign req_word.byte_address = req_ch.byte_address;
   assign req_word.write_data   = req_ch.write_data;

   assign req_ch.ready = !buf_valid_ff || stat.take;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      buf_valid_in = buf_valid_ff;
      if (req_take) begin
         buf_valid_in = 1'b1;
      end else if (stat.take) begin
         buf_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (stat.done) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         buf_word_ff <= req_word;
      end
      if (stat.done) begin
         out_word_ff <= result;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.port_value = out_word_ff.port_value;
   assign rsp_ch.running    = out_word_ff.running;
   assign rsp_ch.repeats    = out_word_ff.repeats;

   lps_engine #(
      .PROGRAM_SLOTS (PROGRAM_SLOTS),
      .PROGRAM_BYTES (PROGRAM_BYTES),
      .AW            (AW)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (buf_valid_ff),
      .item_word  (buf_word_ff),
      .out_free   (out_free),
      .stat       (stat),
      .result     (result),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   lps_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

### tb/sv/lps_score_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_score_pkg
// Status scoreboard for the LED pattern sequencer: keeps its own copy of the
// player state and program memory, and queues the status word that each
// request word should produce.
// ----------------------------------------------------------------------------
package lps_score_pkg;
   import lps_pkg::*;

   localparam int SLOTS = 8;
   localparam int BYTES = 64;

   class lps_scoreboard;
      bit [BYTE_W-1:0]  store   [SLOTS*BYTES];
      bit               written [SLOTS*BYTES];
      bit [BYTE_W-1:0]  led_mask;
      bit [PROG_W-1:0]  cur_prog;
      bit [BADDR_W-1:0] pos;
      bit [TICKS_W-1:0] ticks_left;
      bit               playing;
      bit [BYTE_W-1:0]  wraps;
      bit [BYTE_W-1:0]  port;
      rsp_word_type     status_due [$];
      int               errors;
      int               words;
      int               checked;
      int               reloads;
      int               rewinds;
      int               peak_wraps;

      function new();
         led_mask = LED_MASK_RESET;
      endfunction

      function int base();
         return int'(cur_prog) * BYTES;
      endfunction

      function bit [BYTE_W-1:0] fetch();
         bit [BYTE_W-1:0] b;
         b = store[base() + int'(pos)];
         pos = pos + 1'b1;
         return b;
      endfunction

      // byte offset that the next reload would read before it is written, or -1
      function int missing_byte();
         int p;
         int n;
         if (!playing || ticks_left != 0) return -1;
         p = int'(pos);
         if (!written[base() + p]) return p;
         if (store[base() + p] == END_MARK) begin
            if (!written[base()]) return 0;
            n = 1;
         end else begin
            n = (p + 1) % BYTES;
         end
         return written[base() + n] ? -1 : n;
      endfunction

      function void take_request(req_word_type w);
         bit [BYTE_W-1:0] pat;
         bit [BYTE_W-1:0] dur;
         rsp_word_type    s;
         int              idx;
         words++;
         case (w.action)
            ACT_TICK: begin
               if (playing) begin
                  if (ticks_left != 0) begin
                     ticks_left = ticks_left - 1'b1;
                  end else begin
                     pat = fetch();
                     if (pat == END_MARK) begin
                        if (wraps != WRAP_MAX) wraps = wraps + 1'b1;
                        pos = '0;
                        pat = fetch();
                        rewinds++;
                     end
                     port = (port & ~led_mask) | (pat & led_mask);
                     dur = fetch();
                     ticks_left = TICKS_W'(dur) - 1'b1;
                     reloads++;
                  end
               end
            end
            ACT_START: begin
               if (!(playing && w.program_req == cur_prog)) begin
                  cur_prog   = w.program_req;
                  pos        = '0;
                  ticks_left = '0;
                  wraps      = '0;
                  playing    = 1'b1;
               end
            end
            ACT_STOP: begin
               playing = 1'b0;
               port    = port | led_mask;
            end
            ACT_WRITE: begin
               idx = int'(w.program_req) * BYTES + int'(w.byte_address);
               store[idx]   = w.write_data;
               written[idx] = 1'b1;
            end
         endcase
         if (int'(wraps) > peak_wraps) peak_wraps = int'(wraps);
         s.port_value = port;
         s.running    = playing;
         s.repeats    = wraps;
         status_due.push_back(s);
      endfunction

      function void match_status(rsp_word_type got);
         rsp_word_type want;
         if (status_due.size() == 0) begin
            if (errors < 10)
               $display("unexpected status word: port %h running %b repeats %0d",
                        got.port_value, got.running, got.repeats);
            errors++;
            return;
         end
         want = status_due.pop_front();
         checked++;
         if (got.port_value !== want.port_value || got.running !== want.running ||
             got.repeats !== want.repeats) begin
            if (errors < 10)
               $display("status word %0d: expected port %h running %b repeats %0d, got port %h running %b repeats %0d",
                        checked, want.port_value, want.running, want.repeats,
                        got.port_value, got.running, got.repeats);
            errors++;
         end
      endfunction
   endclass

endpackage

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of led_pattern_sequencer_unit: directed words, a full-length
// program, repeat-count saturation and random program traffic under random
// stalls on both channels, every status word checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb;
   import lps_pkg::*;
   import lps_score_pkg::*;

   localparam int LIMIT = 200000;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [BYTE_W-1:0] csr_wdata;
   lps_scoreboard     sb;
   bit                idle_on;
   int                cycles;
   int                sent;
   int                last_cfg;

   lps_req_if req_ch ();
   lps_rsp_if rsp_ch ();

   led_pattern_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("[led_pattern_sequencer_unit] ERROR");
         $finish;
      end
   end

   initial begin : rsp_side
      rsp_word_type got;
      int           stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.port_value = rsp_ch.port_value;
            got.running    = rsp_ch.running;
            got.repeats    = rsp_ch.repeats;
            sb.match_status(got);
         end
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic req_word_type word(logic [ACTION_W-1:0] act, logic [PROG_W-1:0] prog,
                                         logic [BADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
      req_word_type w;
      w.action       = act;
      w.program_req  = prog;
      w.byte_address = addr;
      w.write_data   = data;
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= w.action;
      req_ch.program_req  <= w.program_req;
      req_ch.byte_address <= w.byte_address;
      req_ch.write_data   <= w.write_data;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_request(w);
      sent++;
   endtask

   task automatic write_byte(input int slot, input int addr, input int data);
      send_word(word(ACT_WRITE, PROG_W'(slot), BADDR_W'(addr), BYTE_W'(data)));
   endtask

   task automatic start_program(input int slot);
      send_word(word(ACT_START, PROG_W'(slot), BADDR_W'($urandom), BYTE_W'($urandom)));
   endtask

   task automatic stop_player();
      send_word(word(ACT_STOP, PROG_W'($urandom), BADDR_W'($urandom), BYTE_W'($urandom)));
   endtask

   // fill bytes the next reload would read before ticking
   task automatic tick();
      int m;
      m = sb.missing_byte();
      while (m >= 0) begin
         write_byte(int'(sb.cur_prog), m,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 3));
         m = sb.missing_byte();
      end
      send_word(word(ACT_TICK, PROG_W'($urandom), BADDR_W'($urandom), BYTE_W'($urandom)));
   endtask

   task automatic load_program(input int slot, input int pairs, input int dmax);
      int i;
      for (i = 0; i < pairs; i++) begin
         write_byte(slot, 2 * i, $urandom_range(0, 254));
         write_byte(slot, 2 * i + 1, $urandom_range(1, dmax));
      end
      write_byte(slot, 2 * pairs, END_MARK);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.status_due.size() != 0);
   endtask

   task automatic set_mask(input logic [BYTE_W-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      sb.led_mask = v;
      csr_we <= 1'b0;
      last_cfg = sent;
   endtask

   initial begin
      int r;
      int a;
      sb = new();
      idle_on = 1'b1;
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.action       <= ACT_TICK;
      req_ch.program_req  <= '0;
      req_ch.byte_address <= '0;
      req_ch.write_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // tick while stopped, all payload bits high
      send_word(word(ACT_TICK, 3'd7, 6'd63, 8'hFF));
      write_byte(1, 0, 8'h00);
      write_byte(1, 1, 8'd1);
      write_byte(1, 2, END_MARK);
      start_program(1);
      start_program(1);
      tick();
      tick();
      tick();
      stop_player();
      tick();
      start_program(1);
      // end marker at byte 0, zero duration
      write_byte(2, 0, END_MARK);
      write_byte(2, 1, 8'h00);
      start_program(2);
      tick();
      tick();
      write_byte(7, 63, 8'hAB);
      write_byte(0, 0, 8'hFE);
      write_byte(0, 1, 8'hFF);
      start_program(0);
      tick();
      tick();
      stop_player();

      // full program without end marker: position wraps past the last byte
      set_mask(8'hFF);
      idle_on = 1'b0;
      for (a = 0; a < BYTES; a++)
         write_byte(3, a, (a % 2 == 0) ? $urandom_range(0, 254) : 1);
      start_program(3);
      repeat (36) tick();
      stop_player();

      // every reload rewinds: drive the repeat count into saturation
      set_mask(8'h00);
      idle_on = 1'b1;
      write_byte(5, 0, END_MARK);
      write_byte(5, 1, 8'd1);
      write_byte(5, 2, END_MARK);
      start_program(5);
      repeat (262) tick();
      stop_player();
      set_mask(LED_MASK_RESET);

      while (sent < 740) begin
         if (sent > 615) idle_on = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 40) begin
            repeat ($urandom_range(3, 15)) tick();
         end else if (r < 55) begin
            load_program($urandom_range(0, 7), $urandom_range(1, 6), $urandom_range(1, 4));
         end else if (r < 72) begin
            start_program(($urandom_range(0, 2) == 0) ? int'(sb.cur_prog) : $urandom_range(0, 7));
         end else if (r < 78) begin
            stop_player();
         end else if (r < 90) begin
            write_byte($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 255));
         end else if (sent - last_cfg > 80) begin
            case ($urandom_range(0, 3))
               0:       set_mask(8'h00);
               1:       set_mask(8'hFF);
               default: set_mask(BYTE_W'($urandom));
            endcase
         end else begin
            tick();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("run: %0d request words, %0d pattern reloads, %0d rewinds, peak repeat count %0d",
               sb.words, sb.reloads, sb.rewinds, sb.peak_wraps);
      $display("run: %0d status words checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.status_due.size() == 0) begin
         $display("[led_pattern_sequencer_unit] OK");
      end else begin
         $display("[led_pattern_sequencer_unit] ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/lps_pkg.sv
rtl/core/lps_if.sv
rtl/core/lps_store.sv
rtl/core/lps_engine.sv
rtl/core/led_pattern_sequencer_unit.sv
tb/sv/lps_score_pkg.sv
tb/sv/tb.sv
